// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define PLSU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define PLSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

// ===== sv/plsu_pkg.sv =====
// ----------------------------------------------------------------------------
// plsu_pkg
// Types, codes and sizes shared by the positional list store unit.
// ----------------------------------------------------------------------------
package plsu_pkg;

    // List geometry.
    localparam int CAPACITY   = 16;
    localparam int ENTRY_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W      = 5;
    localparam int CMP_W      = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    // Request codes.
    localparam logic [2:0] REQ_GET     = 3'd0;
    localparam logic [2:0] REQ_INSERT  = 3'd1;
    localparam logic [2:0] REQ_REMOVE  = 3'd2;
    localparam logic [2:0] REQ_REPLACE = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef logic [ENTRY_BITS-1:0] entry_t;

    // Request transfer payload.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  position;
        logic        append_end;
        logic [31:0] entry_value;
    } req_t;

    // Result transfer payload.
    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } rsp_t;

    // Operation broadcast along the chain of slot cells.
    typedef enum logic [1:0] {
        CHAIN_IDLE,
        CHAIN_INSERT,
        CHAIN_REMOVE,
        CHAIN_REPLACE
    } chain_mode_t;

    typedef struct packed {
        chain_mode_t         mode;
        logic [CMP_W-1:0]    pos;
        logic [CMP_W-1:0]    fill;
        entry_t              value;
    } chain_cmd_t;

endpackage

// ===== sv/plsu_cell.sv =====
// ----------------------------------------------------------------------------
// plsu_cell
// One slot of the list: holds an entry and moves it to or from a neighbor.
// ----------------------------------------------------------------------------
module plsu_cell (
    input  logic                         clk,
    input  logic [plsu_pkg::IDX_W-1:0]   idx,
    input  plsu_pkg::chain_cmd_t         cmd,
    input  plsu_pkg::entry_t             lower_in,
    input  plsu_pkg::entry_t             upper_in,
    output plsu_pkg::entry_t             slot
);

    plsu_pkg::entry_t                slot_reg;
    plsu_pkg::entry_t                slot_next;
    logic [plsu_pkg::CMP_W-1:0]      my_pos;
    logic [plsu_pkg::CMP_W-1:0]      my_pos_inc;

    assign my_pos     = plsu_pkg::CMP_W'(idx);
    assign my_pos_inc = my_pos + plsu_pkg::CMP_W'(1);

    // Decide from the broadcast command what this slot takes in.
    always_comb
    begin
        slot_next = slot_reg;
        case (cmd.mode)
            plsu_pkg::CHAIN_INSERT:
            begin
                if (my_pos == cmd.pos)
                    slot_next = cmd.value;
                else if (my_pos > cmd.pos && my_pos <= cmd.fill)
                    slot_next = lower_in;
            end
            plsu_pkg::CHAIN_REMOVE:
            begin
                if (my_pos >= cmd.pos && my_pos_inc < cmd.fill)
                    slot_next = upper_in;
            end
            plsu_pkg::CHAIN_REPLACE:
            begin
                if (my_pos == cmd.pos)
                    slot_next = cmd.value;
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    // Entry storage; contents are undefined until first written.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

// ===== sv/plsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// plsu_ctrl
// Request decode, fill count, chain command and result register.
// ----------------------------------------------------------------------------
module plsu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  plsu_pkg::req_t       request,
    input  plsu_pkg::entry_t     slots [plsu_pkg::CAPACITY],
    output plsu_pkg::chain_cmd_t cmd,
    output plsu_pkg::rsp_t       response,
    output logic                 done
);

    logic [plsu_pkg::COUNT_W-1:0] fill_reg;
    logic [plsu_pkg::COUNT_W-1:0] fill_next;
    plsu_pkg::rsp_t               rsp_reg;
    plsu_pkg::rsp_t               rsp_next;
    logic                         done_reg;
    logic                         done_next;

    logic [plsu_pkg::CMP_W-1:0]   fill_c;
    logic [plsu_pkg::CMP_W-1:0]   pos_c;
    logic [plsu_pkg::CMP_W-1:0]   ins_pos;
    logic                         pos_in_list;
    plsu_pkg::entry_t             read_entry;
    logic [31:0]                  read_data;

    assign fill_c      = plsu_pkg::CMP_W'(fill_reg);
    assign pos_c       = plsu_pkg::CMP_W'(request.position);
    assign ins_pos     = request.append_end ? fill_c : pos_c;
    assign pos_in_list = (pos_c < fill_c);

    // Read port over the slots; only consulted when the position is in the list.
    assign read_entry = slots[request.position[plsu_pkg::IDX_W-1:0]];
    assign read_data  = 32'(read_entry);

    // Decode the request and work out the new count, result and chain command.
    always_comb
    begin
        fill_next      = fill_reg;
        rsp_next       = '0;
        done_next      = accept;
        cmd.mode       = plsu_pkg::CHAIN_IDLE;
        cmd.pos        = pos_c;
        cmd.fill       = fill_c;
        cmd.value      = plsu_pkg::ENTRY_BITS'(request.entry_value);
        if (accept)
        begin
            case (request.req_type)
                plsu_pkg::REQ_GET:
                begin
                    if (pos_in_list)
                        rsp_next.data_out = read_data;
                    else
                        rsp_next.status = plsu_pkg::ST_BADPOS;
                end
                plsu_pkg::REQ_INSERT:
                begin
                    cmd.pos = ins_pos;
                    if (ins_pos > fill_c)
                        rsp_next.status = plsu_pkg::ST_BADPOS;
                    else if (fill_c >= plsu_pkg::CMP_W'(plsu_pkg::CAPACITY))
                        rsp_next.status = plsu_pkg::ST_FULL;
                    else
                    begin
                        cmd.mode  = plsu_pkg::CHAIN_INSERT;
                        fill_next = fill_reg + plsu_pkg::COUNT_W'(1);
                    end
                end
                plsu_pkg::REQ_REMOVE:
                begin
                    if (pos_in_list)
                    begin
                        rsp_next.data_out = read_data;
                        cmd.mode          = plsu_pkg::CHAIN_REMOVE;
                        fill_next         = fill_reg - plsu_pkg::COUNT_W'(1);
                    end
                    else
                        rsp_next.status = plsu_pkg::ST_BADPOS;
                end
                plsu_pkg::REQ_REPLACE:
                begin
                    if (pos_in_list)
                        cmd.mode = plsu_pkg::CHAIN_REPLACE;
                    else
                        rsp_next.status = plsu_pkg::ST_BADPOS;
                end
                plsu_pkg::REQ_CLEAR:
                begin
                    fill_next = '0;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
        rsp_next.entry_count = 5'(fill_next);
    end

    // Control state: fill count and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= done_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign response = rsp_reg;
    assign done     = done_reg;

endmodule

// ===== sv/positional_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Ordered list addressed by position, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// The result strobe done is registered and rises in the cycle after the request transfer.
// Throughput: one request per cycle; all affected slot cells shift in the same cycle.
// busy is never raised, and the receiver cannot stall the result.
// Reset clears the entry count and the strobe; slot contents stay undefined
// until written, and no clearing pass runs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_store_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  plsu_pkg::req_t request,
    output plsu_pkg::rsp_t response,
    output logic           done
);

    plsu_pkg::chain_cmd_t cmd;
    plsu_pkg::entry_t     slots [plsu_pkg::CAPACITY];
    logic                 accept;
    logic                 rsp_full;
    logic                 rsp_error;

    // Every request is taken in the cycle it is presented.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Controller: decode, count and result register.
    plsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .request  (request),
        .slots    (slots),
        .cmd      (cmd),
        .response (response),
        .done     (done)
    );

    // Chain of slot cells, each linked to its neighbors; the end cells take zero from the missing side.
    for (genvar i = 0; i < plsu_pkg::CAPACITY; i++)
    begin : g_cell
        plsu_pkg::entry_t lower_in;
        plsu_pkg::entry_t upper_in;

        if (i == 0)
        begin : g_head
            assign lower_in = '0;
        end
        else
        begin : g_lower
            assign lower_in = slots[i-1];
        end

        if (i == plsu_pkg::CAPACITY - 1)
        begin : g_tail
            assign upper_in = '0;
        end
        else
        begin : g_upper
            assign upper_in = slots[i+1];
        end

        plsu_cell u_cell (
            .clk      (clk),
            .idx      (plsu_pkg::IDX_W'(i)),
            .cmd      (cmd),
            .lower_in (lower_in),
            .upper_in (upper_in),
            .slot     (slots[i])
        );
    end

    // Result classes used by the checks below.
    assign rsp_full  = done && (response.status == plsu_pkg::ST_FULL);
    assign rsp_error = done && (response.status != plsu_pkg::ST_OK);

    // Checks on the result stream.
    `PLSU_ASSERT_NEXT(a_done_after_transfer, accept, done)
    `PLSU_ASSERT_NEXT(a_no_spurious_done, !accept, !done)
    `PLSU_ASSERT_NOW(a_count_in_range, done, response.entry_count <= 5'(plsu_pkg::CAPACITY))
    `PLSU_ASSERT_NOW(a_full_means_full, rsp_full, response.entry_count == 5'(plsu_pkg::CAPACITY))
    `PLSU_ASSERT_NOW(a_error_zero_data, rsp_error, response.data_out == 32'd0)

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list store unit. Requests go in
// through the start/busy handshake. A scoreboard keeps its own copy of the
// list, works out the result of every accepted request and compares it, field
// by field, with the result strobed out in the next cycle. A short directed
// pass covers the edge cases, then a long random pass pushes the list back
// and forth between empty and full.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1550;
    localparam int GAP_PERCENT     = 29;

    // Scoreboard: shadow list plus the queue of results still to come.
    class list_scoreboard;
        plsu_pkg::entry_t shadow_slots[plsu_pkg::CAPACITY];
        int unsigned      fill_level;
        plsu_pkg::rsp_t   expected_q[$];
        int               errors;

        function new();
            fill_level = 0;
            errors     = 0;
        endfunction

        // Apply one accepted request to the shadow list and queue its result.
        function void note_request(plsu_pkg::req_t req);
            plsu_pkg::rsp_t rsp;
            int unsigned    pos;
            rsp = '0;
            pos = req.position;
            case (req.req_type)
                plsu_pkg::REQ_GET:
                begin
                    if (pos < fill_level)
                        rsp.data_out = 32'(shadow_slots[pos]);
                    else
                        rsp.status = plsu_pkg::ST_BADPOS;
                end
                plsu_pkg::REQ_INSERT:
                begin
                    if (req.append_end)
                        pos = fill_level;
                    // The position check wins over the full check.
                    if (pos > fill_level)
                    begin
                        rsp.status = plsu_pkg::ST_BADPOS;
                    end
                    else if (fill_level >= plsu_pkg::CAPACITY)
                    begin
                        rsp.status = plsu_pkg::ST_FULL;
                    end
                    else
                    begin
                        for (int i = fill_level; i > int'(pos); i--)
                            shadow_slots[i] = shadow_slots[i-1];
                        shadow_slots[pos] = plsu_pkg::entry_t'(req.entry_value);
                        fill_level++;
                    end
                end
                plsu_pkg::REQ_REMOVE:
                begin
                    if (pos < fill_level)
                    begin
                        rsp.data_out = 32'(shadow_slots[pos]);
                        for (int i = pos; i + 1 < int'(fill_level); i++)
                            shadow_slots[i] = shadow_slots[i+1];
                        fill_level--;
                    end
                    else
                    begin
                        rsp.status = plsu_pkg::ST_BADPOS;
                    end
                end
                plsu_pkg::REQ_REPLACE:
                begin
                    if (pos < fill_level)
                        shadow_slots[pos] = plsu_pkg::entry_t'(req.entry_value);
                    else
                        rsp.status = plsu_pkg::ST_BADPOS;
                end
                plsu_pkg::REQ_CLEAR:
                begin
                    fill_level = 0;
                end
                default:
                begin
                    // Unused request codes leave the list alone.
                end
            endcase
            rsp.entry_count = 5'(fill_level);
            expected_q.push_back(rsp);
        endfunction

        // Compare one strobed result with the oldest expectation.
        function void check_response(plsu_pkg::rsp_t got);
            plsu_pkg::rsp_t want;
            if (expected_q.size() == 0)
            begin
                $error("Result transfer with no request outstanding: %p", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.data_out !== want.data_out)
            begin
                $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d",
                       want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    plsu_pkg::req_t request;
    plsu_pkg::rsp_t response;
    logic           done;

    list_scoreboard board;
    bit             gaps_on;
    bit             growing;

    positional_list_store_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .response (response),
        .done     (done)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #400us;
        $display("DONE: errors detected");
        $finish;
    end

    // Monitor: sample results and request transfers at the rising edge.
    always @(posedge clk)
    begin
        if (done)
            board.check_response(response);
        if (rst_n && start && !busy)
            board.note_request(request);
    end

    function automatic plsu_pkg::req_t make_req(logic [2:0] kind, int unsigned pos,
                                                logic app, logic [31:0] value);
        plsu_pkg::req_t req;
        req.req_type    = kind;
        req.position    = 5'(pos);
        req.append_end  = app;
        req.entry_value = value;
        return req;
    endfunction

    // Drive one request from a falling edge and return after its transfer.
    task automatic issue(input plsu_pkg::req_t req);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT)
        begin
            start   <= 1'b0;
            request <= plsu_pkg::req_t'({$urandom(), $urandom()});
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Random request, mostly legal for the current fill, with some noise.
    function automatic plsu_pkg::req_t random_req();
        plsu_pkg::req_t req;
        int unsigned    roll;
        int unsigned    fill;
        fill = board.fill_level;
        roll = $urandom_range(99);
        req  = make_req(plsu_pkg::REQ_GET, 0, 1'($urandom_range(1)), $urandom());
        if (roll < 2)
            req.req_type = plsu_pkg::REQ_CLEAR;
        else if (roll < 4)
            req.req_type = 3'(plsu_pkg::REQ_CLEAR + 3'($urandom_range(3, 1)));
        else if (roll < (growing ? 50 : 20))
            req.req_type = plsu_pkg::REQ_INSERT;
        else if (roll < (growing ? 62 : 58))
            req.req_type = plsu_pkg::REQ_REMOVE;
        else if (roll < 80)
            req.req_type = plsu_pkg::REQ_REPLACE;
        else
            req.req_type = plsu_pkg::REQ_GET;

        if ($urandom_range(99) < 10)
        begin
            req.position = 5'($urandom_range(31));
        end
        else if (req.req_type == plsu_pkg::REQ_INSERT)
        begin
            req.position   = 5'($urandom_range(fill));
            req.append_end = ($urandom_range(99) < 20);
        end
        else
        begin
            req.position = (fill == 0) ? 5'd0 : 5'($urandom_range(fill - 1));
        end
        return req;
    endfunction

    // Stimulus.
    initial
    begin
        board   = new();
        gaps_on = 1'b1;
        growing = 1'b1;
        start   = 1'b0;
        request = '0;
        rst_n   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: requests on an empty list, all rejected.
        issue(make_req(plsu_pkg::REQ_GET, 0, 1'b0, 32'h0));
        issue(make_req(plsu_pkg::REQ_REMOVE, 0, 1'b0, 32'h0));
        issue(make_req(plsu_pkg::REQ_REPLACE, 31, 1'b1, 32'hFFFF_FFFF));
        issue(make_req(plsu_pkg::REQ_INSERT, 1, 1'b0, 32'h1));

        // Directed: insert at the head, the tail, by append and in the middle.
        issue(make_req(plsu_pkg::REQ_INSERT, 0, 1'b0, 32'hFFFF_FFFF));
        issue(make_req(plsu_pkg::REQ_INSERT, 31, 1'b1, 32'h0));
        issue(make_req(plsu_pkg::REQ_INSERT, 0, 1'b0, 32'h1234_5678));
        issue(make_req(plsu_pkg::REQ_INSERT, 3, 1'b0, 32'hA5A5_A5A5));
        issue(make_req(plsu_pkg::REQ_INSERT, 2, 1'b0, $urandom()));
        while (board.fill_level < plsu_pkg::CAPACITY)
            issue(make_req(plsu_pkg::REQ_INSERT, $urandom_range(board.fill_level),
                           1'b0, $urandom()));

        // Directed: full list, position check ahead of the full check.
        issue(make_req(plsu_pkg::REQ_INSERT, 0, 1'b0, 32'h5555_5555));
        issue(make_req(plsu_pkg::REQ_INSERT, 0, 1'b1, 32'hAAAA_AAAA));
        issue(make_req(plsu_pkg::REQ_INSERT, 17, 1'b0, 32'h0));
        issue(make_req(plsu_pkg::REQ_GET, 15, 1'b0, 32'h0));
        issue(make_req(plsu_pkg::REQ_GET, 16, 1'b0, 32'h0));
        issue(make_req(plsu_pkg::REQ_REPLACE, 15, 1'b0, 32'h0));
        issue(make_req(plsu_pkg::REQ_REMOVE, 15, 1'b0, 32'h0));
        issue(make_req(plsu_pkg::REQ_REMOVE, 0, 1'b0, 32'h0));

        // Directed: unused codes, then clear and a bad insert on empty.
        for (int k = 1; k <= 3; k++)
            issue(make_req(3'(plsu_pkg::REQ_CLEAR + 3'(k)), 0, 1'b0, 32'hFFFF_FFFF));
        issue(make_req(plsu_pkg::REQ_CLEAR, 31, 1'b1, 32'h0));
        issue(make_req(plsu_pkg::REQ_INSERT, 16, 1'b0, 32'h7));

        // Random traffic, drifting between a full and an empty list.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            gaps_on = !(n >= 600 && n < 900);
            if (board.fill_level >= plsu_pkg::CAPACITY)
                growing = 1'b0;
            else if (board.fill_level == 0)
                growing = 1'b1;
            else if ($urandom_range(99) < 3)
                growing = !growing;
            issue(random_req());
        end
        start <= 1'b0;

        // Drain: the result follows its request in the next cycle.
        for (int w = 0; w < 50 && board.expected_q.size() != 0; w++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (board.expected_q.size() != 0)
        begin
            $error("%0d results never arrived", board.expected_q.size());
            board.errors++;
        end

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
